// ===== rtl/ovc_pkg.sv =====
// Package with shared constants, types and codes for the overlay compositor.
`timescale 1ns / 1ps

package ovc_pkg;

    // Overlay store geometry.
    localparam int OVERLAY_DEPTH = 65536;
    localparam int ADDR_W        = $clog2(OVERLAY_DEPTH);

    // Pixel and channel layout.
    localparam int PIX_W     = 32;
    localparam int BYTE_W    = 8;
    localparam int LANES     = PIX_W / BYTE_W;
    localparam int ALPHA_LSB = 3 * BYTE_W;
    localparam int PROD_W    = 2 * BYTE_W;
    localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

    // Geometry and offset widths.
    localparam int DIM_W = 12;
    localparam int OFF_W = 13;
    localparam int IDX_W = 2 * DIM_W;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = OFF_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BACK_WIDTH   = 3'd0,
        CFG_FRONT_WIDTH  = 3'd1,
        CFG_FRONT_HEIGHT = 3'd2,
        CFG_X_OFFSET     = 3'd3,
        CFG_Y_OFFSET     = 3'd4
    } t_cfg_idx;

    typedef enum logic {
        CMD_LOAD    = 1'b0,
        CMD_COMPOSE = 1'b1
    } t_cmd;

    // Input word and result word.
    typedef struct packed {
        logic             command;
        logic [PIX_W-1:0] pixel;
        logic             first;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] result_pixel;
        logic             covered;
    } t_out_word;

    // Configuration register set.
    typedef struct packed {
        logic [DIM_W-1:0] back_width;
        logic [DIM_W-1:0] front_width;
        logic [DIM_W-1:0] front_height;
        logic [OFF_W-1:0] x_offset;
        logic [OFF_W-1:0] y_offset;
    } t_cfg;

    // Store access request: a write for loads, a read for composes.
    typedef struct packed {
        logic              load;
        logic [PIX_W-1:0]  pixel;
        logic              covered;
        logic [ADDR_W-1:0] addr;
    } t_mem_req;

    // Background side data that travels alongside the store read.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             covered;
    } t_mem_rsp;

endpackage

// ===== rtl/overlay_alpha_compositor.sv =====
// Top level of the overlay compositor: configuration, stage flow control, units.
//
//  Channel   Direction  Handshake                 Word
//  in        input      i_in_valid / o_in_ready   i_in_word  (command, pixel, first)
//  out       output     o_out_valid / i_out_ready o_out_word (result_pixel, covered)
//  cfg       input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One word per clock is accepted in steady state while the output is not stalled.
// A compose word passes in order through position, index multiply, store access,
// blend multiply, then divide and output register. The single store port is used
// once per word in the access stage. Each stage holds only when the stage after
// it is full and held, so bubbles close up under stall. Reset clears counters and
// stage valids and loads the default configuration; the store needs no clearing.
`timescale 1ns / 1ps

module overlay_alpha_compositor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ovc_pkg::t_in_word              i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ovc_pkg::t_out_word             o_out_word,
    input  logic                           i_cfg_we,
    input  logic [ovc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ovc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ovc_pkg::*;

    t_cfg              r_cfg;
    logic              w_adv_a;
    logic              w_adv_b;
    logic              w_adv_c;
    logic              w_adv_d;
    logic              w_adv_e;
    logic              w_a_valid;
    logic              w_b_valid;
    logic              w_c_valid;
    logic              w_d_valid;
    t_mem_req          w_req;
    t_mem_rsp          w_rsp;
    logic [PIX_W-1:0]  w_front;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.back_width   <= DIM_W'(640);
            r_cfg.front_width  <= DIM_W'(256);
            r_cfg.front_height <= DIM_W'(256);
            r_cfg.x_offset     <= '0;
            r_cfg.y_offset     <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BACK_WIDTH:   r_cfg.back_width   <= i_cfg_data[DIM_W-1:0];
                CFG_FRONT_WIDTH:  r_cfg.front_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRONT_HEIGHT: r_cfg.front_height <= i_cfg_data[DIM_W-1:0];
                CFG_X_OFFSET:     r_cfg.x_offset     <= i_cfg_data[OFF_W-1:0];
                CFG_Y_OFFSET:     r_cfg.y_offset     <= i_cfg_data[OFF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or the stage after it moves on.
    always_comb begin
        w_adv_e = !o_out_valid || i_out_ready;
        w_adv_d = !w_d_valid || w_adv_e;
        w_adv_c = !w_c_valid || w_adv_d;
        w_adv_b = !w_b_valid || w_adv_c;
        w_adv_a = !w_a_valid || w_adv_b;
    end

    assign o_in_ready = w_adv_a;

    ovc_position u_position (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .i_adv_a    (w_adv_a),
        .i_adv_b    (w_adv_b),
        .o_a_valid  (w_a_valid),
        .o_b_valid  (w_b_valid),
        .o_req      (w_req)
    );

    ovc_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv_c     (w_adv_c),
        .i_req_valid (w_b_valid),
        .i_req       (w_req),
        .o_c_valid   (w_c_valid),
        .o_front     (w_front),
        .o_rsp       (w_rsp)
    );

    ovc_blend u_blend (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv_d     (w_adv_d),
        .i_adv_e     (w_adv_e),
        .i_c_valid   (w_c_valid),
        .i_front     (w_front),
        .i_rsp       (w_rsp),
        .o_d_valid   (w_d_valid),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== rtl/ovc_position.sv =====
// Raster position tracking, coverage test and overlay index computation.
`timescale 1ns / 1ps

module ovc_position (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ovc_pkg::t_cfg     i_cfg,
    input  logic              i_in_valid,
    input  ovc_pkg::t_in_word i_in_word,
    input  logic              i_adv_a,
    input  logic              i_adv_b,
    output logic              o_a_valid,
    output logic              o_b_valid,
    output ovc_pkg::t_mem_req o_req
);
    import ovc_pkg::*;

    typedef struct packed {
        logic              load;
        logic [PIX_W-1:0]  pixel;
        logic              in_area;
        logic [DIM_W-1:0]  dx;
        logic [DIM_W-1:0]  dy;
        logic [ADDR_W-1:0] addr;
    } t_pos_stage;

    logic [ADDR_W-1:0] r_load_addr;
    logic [DIM_W-1:0]  r_col;
    logic [DIM_W-1:0]  r_row;
    logic              r_a_valid;
    logic              r_b_valid;
    t_pos_stage        r_a;
    t_mem_req          r_b;

    logic              w_accept;
    logic              w_compose;
    logic [ADDR_W-1:0] w_cur_addr;
    logic [ADDR_W-1:0] n_load_addr;
    logic [DIM_W-1:0]  w_cur_col;
    logic [DIM_W-1:0]  w_cur_row;
    logic [DIM_W+1:0]  w_dx;
    logic [DIM_W+1:0]  w_dy;
    logic              w_inside;
    logic [DIM_W:0]    w_col_inc;
    logic [DIM_W:0]    w_limit;
    logic [DIM_W-1:0]  n_col;
    logic [DIM_W-1:0]  n_row;
    logic [IDX_W-1:0]  w_idx;
    logic              w_idx_ok;

    assign w_accept  = i_in_valid && i_adv_a;
    assign w_compose = (i_in_word.command == CMD_COMPOSE);

    // Load address, restarted by the first flag and wrapped at the store end.
    always_comb begin
        w_cur_addr  = i_in_word.first ? '0 : r_load_addr;
        n_load_addr = (w_cur_addr == ADDR_W'(OVERLAY_DEPTH - 1)) ? '0 : w_cur_addr + 1'b1;
    end

    // Position relative to the overlay origin, and the coverage test.
    always_comb begin
        w_cur_col = i_in_word.first ? '0 : r_col;
        w_cur_row = i_in_word.first ? '0 : r_row;
        w_dx = {2'b00, w_cur_col} - {i_cfg.x_offset[OFF_W-1], i_cfg.x_offset};
        w_dy = {2'b00, w_cur_row} - {i_cfg.y_offset[OFF_W-1], i_cfg.y_offset};
        w_inside = !w_dx[DIM_W+1] && (w_dx[DIM_W:0] < {1'b0, i_cfg.front_width})
                && !w_dy[DIM_W+1] && (w_dy[DIM_W:0] < {1'b0, i_cfg.front_height});
    end

    // Column and row advance. A zero row width wraps at the counter's natural end.
    always_comb begin
        w_col_inc = {1'b0, w_cur_col} + 1'b1;
        w_limit   = (i_cfg.back_width == '0) ? {1'b1, {DIM_W{1'b0}}}
                                             : {1'b0, i_cfg.back_width};
        if (w_col_inc >= w_limit) begin
            n_col = '0;
            n_row = w_cur_row + 1'b1;
        end else begin
            n_col = w_col_inc[DIM_W-1:0];
            n_row = w_cur_row;
        end
    end

    // Overlay index of a covered position; beyond the store counts as uncovered.
    always_comb begin
        w_idx    = IDX_W'(r_a.dy) * IDX_W'(i_cfg.front_width) + IDX_W'(r_a.dx);
        w_idx_ok = 32'(w_idx) < 32'(OVERLAY_DEPTH);
    end

    // Control state: counters and stage valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_addr <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
        end else begin
            if (w_accept) begin
                if (w_compose) begin
                    r_col <= n_col;
                    r_row <= n_row;
                end else begin
                    r_load_addr <= n_load_addr;
                end
            end
            if (i_adv_a) begin
                r_a_valid <= i_in_valid;
            end
            if (i_adv_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_adv_a) begin
            r_a.load    <= !w_compose;
            r_a.pixel   <= i_in_word.pixel;
            r_a.in_area <= w_inside;
            r_a.dx      <= w_dx[DIM_W-1:0];
            r_a.dy      <= w_dy[DIM_W-1:0];
            r_a.addr    <= w_cur_addr;
        end
        if (i_adv_b) begin
            r_b.load    <= r_a.load;
            r_b.pixel   <= r_a.pixel;
            r_b.covered <= !r_a.load && r_a.in_area && w_idx_ok;
            r_b.addr    <= r_a.load ? r_a.addr : w_idx[ADDR_W-1:0];
        end
    end

    assign o_a_valid = r_a_valid;
    assign o_b_valid = r_b_valid;
    assign o_req     = r_b;

endmodule

// ===== rtl/ovc_store.sv =====
// Overlay pixel store: one access per cycle unless held, write for loads, read for composes.
`timescale 1ns / 1ps

module ovc_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv_c,
    input  logic                      i_req_valid,
    input  ovc_pkg::t_mem_req         i_req,
    output logic                      o_c_valid,
    output logic [ovc_pkg::PIX_W-1:0] o_front,
    output ovc_pkg::t_mem_rsp         o_rsp
);
    import ovc_pkg::*;

    logic [PIX_W-1:0] r_store [OVERLAY_DEPTH];
    logic [PIX_W-1:0] r_front;
    logic             r_c_valid;
    t_mem_rsp         r_rsp;

    // All accesses happen in this one stage in item order, so a read
    // always sees every load that was accepted before it.
    always_ff @(posedge i_clk) begin
        if (i_adv_c && i_req_valid && i_req.load) begin
            r_store[i_req.addr] <= i_req.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv_c) begin
            r_front <= r_store[i_req.addr];
        end
    end

    // Loads retire here; only composes continue to the blender.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (i_adv_c) begin
            r_c_valid <= i_req_valid && !i_req.load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv_c) begin
            r_rsp.pixel   <= i_req.pixel;
            r_rsp.covered <= i_req.covered;
        end
    end

    assign o_c_valid = r_c_valid;
    assign o_front   = r_front;
    assign o_rsp     = r_rsp;

endmodule

// ===== rtl/ovc_blend.sv =====
// Per-byte blend of overlay over background, divide by 255 and output register.
`timescale 1ns / 1ps

module ovc_blend (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv_d,
    input  logic                      i_adv_e,
    input  logic                      i_c_valid,
    input  logic [ovc_pkg::PIX_W-1:0] i_front,
    input  ovc_pkg::t_mem_rsp         i_rsp,
    output logic                      o_d_valid,
    output logic                      o_out_valid,
    output ovc_pkg::t_out_word        o_out_word
);
    import ovc_pkg::*;

    logic [BYTE_W-1:0] w_alpha;
    logic [BYTE_W-1:0] w_inv_alpha;
    logic [PROD_W-1:0] w_sum  [LANES];
    logic [PROD_W:0]   w_corr [LANES];
    logic [PIX_W-1:0]  w_blend;

    logic              r_d_valid;
    logic [PROD_W-1:0] r_d_sum [LANES];
    t_mem_rsp          r_d_rsp;
    logic              r_e_valid;
    t_out_word         r_e_word;

    // Weighted sum per byte: front*a + back*(255-a), at most 255*255.
    always_comb begin
        w_alpha     = i_front[ALPHA_LSB +: BYTE_W];
        w_inv_alpha = BYTE_MAX - w_alpha;
        for (int i = 0; i < LANES; i++) begin
            w_sum[i] = PROD_W'(i_front[i*BYTE_W +: BYTE_W]) * PROD_W'(w_alpha)
                     + PROD_W'(i_rsp.pixel[i*BYTE_W +: BYTE_W]) * PROD_W'(w_inv_alpha);
        end
    end

    // Exact floor division by 255 for sums up to 255*255: (x + 1 + (x >> 8)) >> 8.
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_corr[i] = (PROD_W+1)'(r_d_sum[i]) + 1'b1
                      + (PROD_W+1)'(r_d_sum[i] >> BYTE_W);
            w_blend[i*BYTE_W +: BYTE_W] = w_corr[i][BYTE_W +: BYTE_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
        end else begin
            if (i_adv_d) begin
                r_d_valid <= i_c_valid;
            end
            if (i_adv_e) begin
                r_e_valid <= r_d_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv_d) begin
            r_d_sum <= w_sum;
            r_d_rsp <= i_rsp;
        end
        if (i_adv_e) begin
            r_e_word.result_pixel <= r_d_rsp.covered ? w_blend : r_d_rsp.pixel;
            r_e_word.covered      <= r_d_rsp.covered;
        end
    end

    assign o_d_valid   = r_d_valid;
    assign o_out_valid = r_e_valid;
    assign o_out_word  = r_e_word;

endmodule

// ===== rtl/ovc_checker.sv =====
// Port-level checker for the overlay compositor, bound to the top level.
`timescale 1ns / 1ps

module ovc_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input ovc_pkg::t_in_word              i_in_word,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input ovc_pkg::t_out_word             o_out_word,
    input logic                           i_cfg_we,
    input logic [ovc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [ovc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ovc_pkg::*;

    // A result word that is not taken stays, unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed while stalled");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    // A free output register means the whole pipeline can move, so input is taken.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out_valid || i_out_ready) |-> o_in_ready)
        else $error("input stalled although the output side is free");

    // With the output side ready throughout, an accepted compose word reaches the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_word.command == CMD_COMPOSE)
        ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> o_out_valid)
        else $error("compose word did not reach the output in time");

endmodule

bind overlay_alpha_compositor ovc_checker u_ovc_checker (.*);

// ===== sim/tb.sv =====
// Self-checking testbench for the overlay compositor with a built-in blend predictor.
`timescale 1ns / 1ps

module tb;
    import ovc_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 10;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_ITEMS  = 330;
    localparam int PRELOAD_WORDS = 80;
    localparam int TIMEOUT_NS    = 20_000_000;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_MOSTLY} t_rx_mode;

    // Clock, reset and the driven side of every port.
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    t_in_word              in_word = '0;
    logic                  out_ready = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_BACK_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    t_out_word             o_out_word;

    // Predictor state: overlay copy, counters and geometry registers.
    logic [PIX_W-1:0]  overlay_copy [0:OVERLAY_DEPTH-1];
    logic [ADDR_W-1:0] load_ptr = '0;
    logic [DIM_W-1:0]  col_cnt = '0;
    logic [DIM_W-1:0]  row_cnt = '0;
    logic [DIM_W-1:0]  bw_reg = DIM_W'(640);
    logic [DIM_W-1:0]  fw_reg = DIM_W'(256);
    logic [DIM_W-1:0]  fh_reg = DIM_W'(256);
    logic [OFF_W-1:0]  xo_reg = '0;
    logic [OFF_W-1:0]  yo_reg = '0;

    // Composed pixels still owed by the block, oldest first.
    t_out_word composed_q [$];
    t_out_word want_word;
    int        mismatches = 0;

    // Pacing of both sides.
    int       gap_max = 4;
    int       burst_max = 24;
    int       burst_left = 0;
    int       rx_hold = 0;
    t_rx_mode rx_mode = RX_ALWAYS;

    overlay_alpha_compositor DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #TIMEOUT_NS;
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Blends one overlay pixel over one background pixel, all four lanes.
    function automatic logic [PIX_W-1:0] blend_over(input logic [PIX_W-1:0] front,
                                                    input logic [PIX_W-1:0] back);
        int               a;
        int               f;
        int               b;
        int               full;
        logic [PIX_W-1:0] res;
        full = int'(BYTE_MAX);
        a    = int'(front[ALPHA_LSB +: BYTE_W]);
        for (int lane = 0; lane < LANES; lane++) begin
            f = int'(front[lane*BYTE_W +: BYTE_W]);
            b = int'(back[lane*BYTE_W +: BYTE_W]);
            res[lane*BYTE_W +: BYTE_W] = BYTE_W'((f * a + b * (full - a)) / full);
        end
        return res;
    endfunction

    // Applies one accepted word to the predictor and queues the expected pixel.
    task automatic track_word(input t_in_word w);
        int        dx;
        int        dy;
        int        idx;
        int        limit;
        t_out_word r;
        if (w.command == CMD_LOAD) begin
            if (w.first) load_ptr = '0;
            overlay_copy[load_ptr] = w.pixel;
            load_ptr = load_ptr + 1'b1;
        end else begin
            if (w.first) begin
                col_cnt = '0;
                row_cnt = '0;
            end
            dx = int'(col_cnt) - int'($signed(xo_reg));
            dy = int'(row_cnt) - int'($signed(yo_reg));
            r.result_pixel = w.pixel;
            r.covered      = 1'b0;
            if (dx >= 0 && dx < int'(fw_reg) && dy >= 0 && dy < int'(fh_reg)) begin
                idx = dy * int'(fw_reg) + dx;
                // Positions whose index runs past the store are left uncovered.
                if (idx < OVERLAY_DEPTH) begin
                    r.result_pixel = blend_over(overlay_copy[idx], w.pixel);
                    r.covered      = 1'b1;
                end
            end
            // A zero back width lets the column run to its natural end.
            limit = (bw_reg == '0) ? (1 << DIM_W) : int'(bw_reg);
            if (int'(col_cnt) + 1 >= limit) begin
                col_cnt = '0;
                row_cnt = row_cnt + 1'b1;
            end else begin
                col_cnt = col_cnt + 1'b1;
            end
            composed_q.push_back(r);
        end
    endtask

    function automatic logic [PIX_W-1:0] rand_pixel();
        logic [PIX_W-1:0] p;
        p = $urandom;
        // Lean on the opaque and clear alpha ends now and then.
        case ($urandom_range(0, 3))
            0: p[ALPHA_LSB +: BYTE_W] = '0;
            1: p[ALPHA_LSB +: BYTE_W] = BYTE_MAX;
            default: ;
        endcase
        return p;
    endfunction

    function automatic t_in_word make_word(input t_cmd cmd, input logic [PIX_W-1:0] pixel,
                                           input logic restart);
        t_in_word w;
        w.command = cmd;
        w.pixel   = pixel;
        w.first   = restart;
        return w;
    endfunction

    // Sends one word in bursts with random gaps, then tracks it once accepted.
    task automatic send_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, burst_max);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
        track_word(w);
    endtask

    task automatic send_composes(input int count, input logic restart);
        for (int i = 0; i < count; i++) begin
            send_word(make_word(CMD_COMPOSE, rand_pixel(), restart && i == 0));
        end
    endtask

    // Lowers valid and waits until every composed pixel has come back.
    task automatic wait_drained();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge i_clk);
        while (composed_q.size() != 0) @(posedge i_clk);
        // Load words give no result but may still be in the pipeline.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes all five geometry registers on consecutive cycles.
    task automatic write_geometry(input int bw, input int fw, input int fh,
                                  input int xo, input int yo);
        t_cfg_idx              reg_order [5];
        logic [CFG_DATA_W-1:0] reg_val [5];
        reg_order = '{CFG_BACK_WIDTH, CFG_FRONT_WIDTH, CFG_FRONT_HEIGHT,
                      CFG_X_OFFSET, CFG_Y_OFFSET};
        reg_val   = '{CFG_DATA_W'(bw), CFG_DATA_W'(fw), CFG_DATA_W'(fh),
                      CFG_DATA_W'(xo), CFG_DATA_W'(yo)};
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= reg_order[i];
            cfg_data  <= reg_val[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        bw_reg = DIM_W'(bw);
        fw_reg = DIM_W'(fw);
        fh_reg = DIM_W'(fh);
        xo_reg = OFF_W'(xo);
        yo_reg = OFF_W'(yo);
    endtask

    // Receiver: stalls on its own pattern, or holds off while rx_hold counts down.
    initial begin
        int ph;
        ph = 0;
        forever begin
            @(posedge i_clk);
            ph++;
            if (rx_hold > 0) begin
                out_ready <= 1'b0;
                rx_hold--;
            end else begin
                case (rx_mode)
                    RX_ALWAYS:   out_ready <= 1'b1;
                    RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
                    RX_PERIODIC: out_ready <= (ph % 7) < 3;
                    default:     out_ready <= $urandom_range(0, 9) != 0;
                endcase
            end
        end
    end

    // Each accepted result word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (composed_q.size() == 0) begin
                report_mismatch("result word with none expected",
                                o_out_word.result_pixel, '0);
            end else begin
                want_word = composed_q.pop_front();
                if (o_out_word.result_pixel !== want_word.result_pixel)
                    report_mismatch("result_pixel", o_out_word.result_pixel,
                                    want_word.result_pixel);
                if (o_out_word.covered !== want_word.covered)
                    report_mismatch("covered", 32'(o_out_word.covered),
                                    32'(want_word.covered));
            end
        end
    end

    // Loads the low store entries. Every geometry used later keeps its covered
    // positions on these entries, so no read hits an entry that was never loaded.
    task automatic test_store_preload();
        gap_max = 1;
        rx_mode = RX_ALWAYS;
        for (int i = 0; i < PRELOAD_WORDS; i++) begin
            send_word(make_word(CMD_LOAD, rand_pixel(), i == 0));
        end
        wait_drained();
    endtask

    // Geometry left at its reset values covers the top left corner.
    task automatic test_reset_geometry();
        rx_mode = RX_COIN;
        send_composes(4, 1'b1);
        wait_drained();
    endtask

    // Clear, opaque and half alpha over all-zero, all-one and mixed backgrounds.
    task automatic test_blend_corners();
        gap_max = 3;
        send_word(make_word(CMD_LOAD, 32'h00FF_FFFF, 1'b1));
        send_word(make_word(CMD_LOAD, 32'hFF12_3456, 1'b0));
        send_word(make_word(CMD_LOAD, 32'h80FF_00AA, 1'b0));
        send_word(make_word(CMD_LOAD, 32'hFFFF_FFFF, 1'b0));
        wait_drained();
        write_geometry(4, 2, 2, 0, 0);
        send_word(make_word(CMD_COMPOSE, 32'hFFFF_FFFF, 1'b1));
        send_word(make_word(CMD_COMPOSE, 32'h0000_0000, 1'b0));
        send_word(make_word(CMD_COMPOSE, 32'hFFFF_FFFF, 1'b0));
        send_word(make_word(CMD_COMPOSE, 32'h0000_0000, 1'b0));
        send_word(make_word(CMD_COMPOSE, 32'h0000_0000, 1'b0));
        send_word(make_word(CMD_COMPOSE, 32'hA5A5_A5A5, 1'b0));
        wait_drained();
    endtask

    // A huge overlay: its first row lies in the store, while positions whose index
    // is exactly the store end or beyond count as uncovered.
    task automatic test_overlay_beyond_store();
        write_geometry(8, 4095, 4095, 0, 0);
        send_composes(8, 1'b1);
        wait_drained();
        write_geometry(8, 4095, 4095, -16, -16);
        send_composes(8, 1'b1);
        wait_drained();
    endtask

    // Zero width, zero height and zero back width.
    task automatic test_zero_sizes();
        write_geometry(8, 0, 4, 0, 0);
        send_composes(3, 1'b1);
        wait_drained();
        write_geometry(0, 4, 0, 0, 0);
        send_composes(3, 1'b1);
        wait_drained();
    endtask

    // Shrinking the back width below the current column wraps on the next word.
    task automatic test_column_past_row_end();
        write_geometry(64, 4, 4, 0, 1);
        send_composes(40, 1'b1);
        wait_drained();
        write_geometry(16, 4, 4, 0, 1);
        send_composes(3, 1'b0);
        wait_drained();
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_hold();
        gap_max = 0;
        rx_mode = RX_ALWAYS;
        write_geometry(24, 6, 6, 2, 1);
        rx_hold = 100;
        send_composes(60, 1'b1);
        wait_drained();
    endtask

    function automatic int pick_dim(input int hi_small);
        case ($urandom_range(0, 7))
            0:       return 4095;
            1:       return 1;
            default: return $urandom_range(1, hi_small);
        endcase
    endfunction

    // Overlay size whose covered indices stay within the preloaded entries:
    // a full-size side is only paired with a single line on the other side.
    task automatic pick_front(output int fw, output int fh);
        case ($urandom_range(0, 5))
            0: begin
                fw = 4095;
                fh = 1;
            end
            1: begin
                fw = 1;
                fh = 4095;
            end
            default: begin
                fw = $urandom_range(1, 8);
                fh = $urandom_range(1, 8);
            end
        endcase
    endtask

    function automatic int pick_offset();
        case ($urandom_range(0, 9))
            0:       return -4096;
            1:       return 4095;
            default: return $urandom_range(0, 24) - 6;
        endcase
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        if ($urandom_range(0, 99) < 85) begin
            w = make_word(CMD_COMPOSE, rand_pixel(), $urandom_range(0, 39) == 0);
        end else begin
            w = make_word(CMD_LOAD, rand_pixel(), $urandom_range(0, 7) == 0);
        end
        return w;
    endfunction

    // Phases of random words, each under its own geometry and pacing.
    task automatic test_random_phases();
        int phase;
        int n;
        int total;
        int fw;
        int fh;
        phase = 0;
        total = 0;
        while (total < RANDOM_ITEMS) begin
            case (phase)
                0:       write_geometry(4095, 4095, 4095, 0, 0);
                1:       write_geometry(1, 1, 1, -4096, -4096);
                2:       write_geometry(4095, 1, 4095, 4095, 4095);
                default: begin
                    pick_front(fw, fh);
                    write_geometry($urandom_range(0, 19) == 0 ? 0 : pick_dim(40),
                                   fw, fh, pick_offset(), pick_offset());
                end
            endcase
            // Phase one runs with no idling on either side.
            if (phase == 1) begin
                rx_mode = RX_ALWAYS;
                gap_max = 0;
            end else begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                gap_max = $urandom_range(0, 6);
            end
            n = $urandom_range(30, 60);
            send_word(make_word(CMD_COMPOSE, rand_pixel(), 1'b1));
            for (int i = 1; i < n; i++) send_word(rand_word());
            wait_drained();
            total += n;
            phase++;
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_store_preload();
        test_reset_geometry();
        test_blend_corners();
        test_overlay_beyond_store();
        test_zero_sizes();
        test_column_past_row_end();
        test_output_hold();
        test_random_phases();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== overlay_alpha_compositor.f =====
rtl/ovc_pkg.sv
rtl/ovc_position.sv
rtl/ovc_store.sv
rtl/ovc_blend.sv
rtl/overlay_alpha_compositor.sv
rtl/ovc_checker.sv
sim/tb.sv
